FILE: rtl/dual_key_lookup_table_unit_macros.svh
// ---------------------------------------------------------------------------
// dual key lookup table assertion macros
// shared assertion forms; empty when SYNTHESIS is set
// ---------------------------------------------------------------------------
`ifndef DUAL_KEY_LOOKUP_TABLE_UNIT_MACROS_SVH
`define DUAL_KEY_LOOKUP_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define DKL_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define DKL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DKL_ASSERT_SAME(label, ante, cons, msg)
`define DKL_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: rtl/dkl_pkg.sv
// ---------------------------------------------------------------------------
// dkl_pkg
// types and constants of the dual key lookup table unit
// ---------------------------------------------------------------------------
`default_nettype none

package dkl_pkg;

	localparam int FIRST_DEPTH  = 16;
	localparam int SECOND_DEPTH = 16;
	localparam int KEY_WIDTH    = 32;
	localparam int VALUE_WIDTH  = 32;
	localparam int FUNC_WIDTH   = 2;
	localparam int COUNT_WIDTH  = $clog2(FIRST_DEPTH + 1);

	localparam logic [FUNC_WIDTH-1:0] FUNC_INSERT        = 2'd0;
	localparam logic [FUNC_WIDTH-1:0] FUNC_LOOKUP_FIRST  = 2'd1;
	localparam logic [FUNC_WIDTH-1:0] FUNC_LOOKUP_SECOND = 2'd2;

	typedef struct packed {
		logic [FUNC_WIDTH-1:0]  func;
		logic [KEY_WIDTH-1:0]   first_key;
		logic [KEY_WIDTH-1:0]   second_key;
		logic [VALUE_WIDTH-1:0] new_value;
	} req_t;

	typedef struct packed {
		logic                   found;
		logic [VALUE_WIDTH-1:0] read_value;
		logic [COUNT_WIDTH-1:0] entry_count;
		logic                   first_added;
		logic                   second_added;
		logic                   dropped_full;
	} rsp_t;

	typedef struct packed {
		logic                   hit;
		logic                   full;
		logic [VALUE_WIDTH-1:0] value;
	} lookup_stat_t;

	typedef struct packed {
		logic                   en;
		logic [VALUE_WIDTH-1:0] value;
	} table_wr_t;

endpackage

`default_nettype wire

FILE: rtl/dkl_first_table.sv
// ---------------------------------------------------------------------------
// dkl_first_table
// first key table: parallel match, lowest free slot insert, entry count
// ---------------------------------------------------------------------------
`default_nettype none

`include "dual_key_lookup_table_unit_macros.svh"

module dkl_first_table (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [dkl_pkg::KEY_WIDTH-1:0]  key,
	input  wire dkl_pkg::table_wr_t             wr,
	output dkl_pkg::lookup_stat_t               stat,
	output logic [dkl_pkg::COUNT_WIDTH-1:0]     count
);
	import dkl_pkg::*;

	logic [FIRST_DEPTH-1:0]  valid_q;
	logic [KEY_WIDTH-1:0]    key_q   [FIRST_DEPTH];
	logic [VALUE_WIDTH-1:0]  value_q [FIRST_DEPTH];
	logic [COUNT_WIDTH-1:0]  count_q;
	logic [FIRST_DEPTH-1:0]  hit_vec;
	logic [FIRST_DEPTH-1:0]  free_oh;
	logic [VALUE_WIDTH-1:0]  hit_value;

	// lowest clear valid bit
	assign free_oh = ~valid_q & (valid_q + FIRST_DEPTH'(1));

	always_comb begin
		hit_value = '0;
		for (int i = 0; i < FIRST_DEPTH; i++) begin
			hit_vec[i] = valid_q[i] && (key_q[i] == key);
			if (hit_vec[i]) begin
				hit_value = hit_value | value_q[i];
			end
		end
	end

	assign stat.hit   = |hit_vec;
	assign stat.full  = &valid_q;
	assign stat.value = hit_value;
	assign count      = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (wr.en) begin
			valid_q <= valid_q | free_oh;
			count_q <= count_q + COUNT_WIDTH'(1);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < FIRST_DEPTH; i++) begin
			if (wr.en && free_oh[i]) begin
				key_q[i]   <= key;
				value_q[i] <= wr.value;
			end
		end
	end

	`DKL_ASSERT_SAME(a_count_matches_valid, 1'b1, $countones(valid_q) == int'(count_q), "first count out of step with valid bits")
	`DKL_ASSERT_SAME(a_first_hit_unique, 1'b1, $onehot0(hit_vec), "first key stored twice")
	`DKL_ASSERT_SAME(a_first_write_legal, wr.en, !stat.hit && !stat.full, "first insert on hit or full table")

endmodule

`default_nettype wire

FILE: rtl/dkl_second_table.sv
// ---------------------------------------------------------------------------
// dkl_second_table
// second key table: parallel match, lowest free slot insert, linked value
// ---------------------------------------------------------------------------
`default_nettype none

`include "dual_key_lookup_table_unit_macros.svh"

module dkl_second_table (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [dkl_pkg::KEY_WIDTH-1:0]  key,
	input  wire dkl_pkg::table_wr_t             wr,
	output dkl_pkg::lookup_stat_t               stat
);
	import dkl_pkg::*;

	logic [SECOND_DEPTH-1:0] valid_q;
	logic [KEY_WIDTH-1:0]    key_q   [SECOND_DEPTH];
	// copy of the linked first entry value; first entries never change once set
	logic [VALUE_WIDTH-1:0]  value_q [SECOND_DEPTH];
	logic [SECOND_DEPTH-1:0] hit_vec;
	logic [SECOND_DEPTH-1:0] free_oh;
	logic [VALUE_WIDTH-1:0]  hit_value;

	assign free_oh = ~valid_q & (valid_q + SECOND_DEPTH'(1));

	always_comb begin
		hit_value = '0;
		for (int i = 0; i < SECOND_DEPTH; i++) begin
			hit_vec[i] = valid_q[i] && (key_q[i] == key);
			if (hit_vec[i]) begin
				hit_value = hit_value | value_q[i];
			end
		end
	end

	assign stat.hit   = |hit_vec;
	assign stat.full  = &valid_q;
	assign stat.value = hit_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q <= valid_q | free_oh;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < SECOND_DEPTH; i++) begin
			if (wr.en && free_oh[i]) begin
				key_q[i]   <= key;
				value_q[i] <= wr.value;
			end
		end
	end

	`DKL_ASSERT_SAME(a_second_hit_unique, 1'b1, $onehot0(hit_vec), "second key stored twice")
	`DKL_ASSERT_NEXT(a_second_fill, wr.en, $countones(valid_q) == $past($countones(valid_q)) + 1, "second insert did not take one slot")

endmodule

`default_nettype wire

FILE: rtl/dual_key_lookup_table_unit.sv
// ---------------------------------------------------------------------------
// dual_key_lookup_table_unit
// two key associative table, when not stalled one request per cycle
// ---------------------------------------------------------------------------
// an accepted request is registered in stage s1, then its response in rsp_q
// throughput: 1 request per cycle unless stalled; match, insert and count settle
// in one stage against flip-flop key tables with a parallel compare over every entry
// reset: valid bits, entry count and pipeline valids clear; stores are not reset
`default_nettype none

`include "dual_key_lookup_table_unit_macros.svh"

module dual_key_lookup_table_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire dkl_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output dkl_pkg::rsp_t      rsp
);
	import dkl_pkg::*;

	logic                   valid_s1;
	req_t                   req_s1;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;
	logic                   advance;
	lookup_stat_t           first_stat;
	lookup_stat_t           second_stat;
	table_wr_t              first_wr;
	table_wr_t              second_wr;
	logic [COUNT_WIDTH-1:0] count;
	logic                   is_insert;
	logic                   slot_ok;
	rsp_t                   rsp_next;

	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	dkl_first_table u_first (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (req_s1.first_key),
		.wr     (first_wr),
		.stat   (first_stat),
		.count  (count)
	);

	dkl_second_table u_second (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (req_s1.second_key),
		.wr     (second_wr),
		.stat   (second_stat)
	);

	assign is_insert = (req_s1.func == FUNC_INSERT);
	// first key has a slot to link to
	assign slot_ok   = first_stat.hit || !first_stat.full;

	assign first_wr.en     = advance && is_insert && !first_stat.hit && !first_stat.full;
	assign first_wr.value  = req_s1.new_value;
	assign second_wr.en    = advance && is_insert && slot_ok && !second_stat.hit
		&& !second_stat.full;
	assign second_wr.value = first_stat.hit ? first_stat.value : req_s1.new_value;

	always_comb begin
		rsp_next              = '0;
		rsp_next.entry_count  = count;
		case (req_s1.func)
			FUNC_INSERT: begin
				rsp_next.first_added  = !first_stat.hit && !first_stat.full;
				rsp_next.second_added = slot_ok && !second_stat.hit && !second_stat.full;
				rsp_next.dropped_full = (!first_stat.hit && first_stat.full)
					|| (slot_ok && !second_stat.hit && second_stat.full);
				if (!first_stat.hit && !first_stat.full) begin
					rsp_next.entry_count = count + COUNT_WIDTH'(1);
				end
			end
			FUNC_LOOKUP_FIRST: begin
				rsp_next.found      = first_stat.hit;
				rsp_next.read_value = first_stat.value;
			end
			FUNC_LOOKUP_SECOND: begin
				rsp_next.found      = second_stat.hit;
				rsp_next.read_value = second_stat.value;
			end
			default: begin
				rsp_next.found = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`DKL_ASSERT_SAME(a_lookup_no_insert_flags, rsp_valid_q && rsp_q.found, !rsp_q.first_added && !rsp_q.second_added && !rsp_q.dropped_full, "lookup response carries insert flags")
	`DKL_ASSERT_SAME(a_no_write_when_held, !advance, !first_wr.en && !second_wr.en, "table written while stage held")
	`DKL_ASSERT_NEXT(a_count_follows_add, advance && rsp_next.first_added, rsp_q.entry_count == count, "response count differs from table count")

endmodule

`default_nettype wire
